// ===== src/aepk_pkg.sv =====
`timescale 1ns / 1ps

package aepk_pkg;

	// parser states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_ESC  = 2'd1,
		ST_CSI  = 2'd2,
		ST_SS3  = 2'd3
	} parse_state_t;

	// configuration register indexes
	localparam logic [1:0] REG_ESCAPE_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_STOP_HOLD      = 2'd1;
	localparam logic [1:0] REG_QUEUE_LIMIT    = 2'd2;

	// reset values of the configuration registers
	localparam logic [7:0] RST_ESCAPE_TIMEOUT = 8'd5;
	localparam logic [7:0] RST_STOP_HOLD      = 8'd2;
	localparam logic [3:0] RST_QUEUE_LIMIT    = 4'd10;

	// terminal bytes
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_ETX   = 8'h03;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_Q     = 8'h51;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	// petscii key codes
	localparam logic [7:0] PK_NONE   = 8'h00;
	localparam logic [7:0] PK_RETURN = 8'h0D;
	localparam logic [7:0] PK_DELETE = 8'h14;
	localparam logic [7:0] PK_UP     = 8'h91;
	localparam logic [7:0] PK_DOWN   = 8'h11;
	localparam logic [7:0] PK_RIGHT  = 8'h1D;
	localparam logic [7:0] PK_LEFT   = 8'h9D;
	localparam logic [7:0] PK_HOME   = 8'h13;
	localparam logic [7:0] PK_F1     = 8'h85;
	localparam logic [7:0] PK_F2     = 8'h89;
	localparam logic [7:0] PK_F3     = 8'h86;
	localparam logic [7:0] PK_F4     = 8'h8A;
	localparam logic [7:0] PK_F5     = 8'h87;
	localparam logic [7:0] PK_F6     = 8'h8B;
	localparam logic [7:0] PK_F7     = 8'h88;
	localparam logic [7:0] PK_F8     = 8'h8C;

	// parser state carried between items
	typedef struct packed {
		parse_state_t pstate;
		logic [7:0]   timer;
		logic [7:0]   csi;
		logic [7:0]   stop_cnt;
	} parse_regs_t;

	// configuration as seen by the parser
	typedef struct packed {
		logic [7:0] escape_timeout;
		logic [7:0] stop_hold;
		logic [3:0] queue_limit;
	} parse_cfg_t;

	// result of one item
	typedef struct packed {
		logic       key_valid;
		logic [7:0] key_code;
		logic       stop_down;
	} parse_res_t;

	// plain bytes in idle
	function automatic logic [7:0] plain_map(input logic [7:0] c);
		logic [7:0] r;
		if (c == CH_CR || c == CH_LF) r = PK_RETURN;
		else if (c == CH_BS || c == CH_DEL) r = PK_DELETE;
		else if (c >= CH_LC_A && c <= CH_LC_Z) r = c - 8'h20;
		else if (c >= CH_SPACE && c <= CH_UNDER) r = c;
		else r = PK_NONE;
		return r;
	endfunction

	// cursor letters
	function automatic logic [7:0] cursor_map(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			CH_A:    r = PK_UP;
			CH_B:    r = PK_DOWN;
			CH_C:    r = PK_RIGHT;
			CH_D:    r = PK_LEFT;
			default: r = PK_NONE;
		endcase
		return r;
	endfunction

	// csi parameter before the tilde
	function automatic logic [7:0] tilde_map(input logic [7:0] p);
		logic [7:0] r;
		case (p)
			8'd1:    r = PK_HOME;
			8'd3:    r = PK_DELETE;
			8'd4:    r = PK_HOME;
			8'd11:   r = PK_F1;
			8'd12:   r = PK_F2;
			8'd13:   r = PK_F3;
			8'd14:   r = PK_F4;
			8'd15:   r = PK_F5;
			8'd17:   r = PK_F6;
			8'd18:   r = PK_F7;
			8'd19:   r = PK_F8;
			default: r = PK_NONE;
		endcase
		return r;
	endfunction

endpackage

// ===== src/aepk_step.sv =====
`timescale 1ns / 1ps

module aepk_step import aepk_pkg::*; (
	input  parse_regs_t cur,
	input  parse_cfg_t  cfg,
	input  logic        char_valid,
	input  logic [7:0]  char_code,
	input  logic [3:0]  queue_level,
	output parse_regs_t nxt,
	output parse_res_t  res
);

	logic [7:0] key;
	logic [7:0] stop_load;
	logic [7:0] stop_dec;
	logic       expired;
	logic [7:0] timer_dec;
	logic [7:0] csi_acc;
	logic       is_digit;

	// shared helpers
	assign stop_load = (cfg.stop_hold != 8'd0) ? cfg.stop_hold : 8'd1;
	assign stop_dec  = (cur.stop_cnt != 8'd0) ? cur.stop_cnt - 8'd1 : 8'd0;
	assign expired   = cur.timer <= 8'd1;
	assign timer_dec = expired ? 8'd0 : cur.timer - 8'd1;
	assign is_digit  = char_code >= CH_ZERO && char_code <= CH_NINE;
	assign csi_acc   = {cur.csi[4:0], 3'b000} + {cur.csi[6:0], 1'b0} + (char_code - CH_ZERO);

	// parser next state and key
	always_comb begin
		nxt          = cur;
		nxt.stop_cnt = stop_dec;
		key          = PK_NONE;
		case (cur.pstate)
			ST_IDLE: begin
				if (char_valid) begin
					if (char_code == CH_ESC) begin
						nxt.pstate = ST_ESC;
						nxt.timer  = cfg.escape_timeout;
					end else if (char_code == CH_ETX) begin
						nxt.stop_cnt = stop_load;
					end else begin
						key = plain_map(char_code);
					end
				end
			end
			ST_ESC: begin
				if (char_valid && char_code == CH_LBRK) begin
					nxt.pstate = ST_CSI;
					nxt.timer  = cfg.escape_timeout;
					nxt.csi    = 8'd0;
				end else if (char_valid && char_code == CH_O) begin
					nxt.pstate = ST_SS3;
					nxt.timer  = cfg.escape_timeout;
				end else if (char_valid) begin
					nxt.stop_cnt = stop_load;
					nxt.pstate   = ST_IDLE;
				end else begin
					nxt.timer = timer_dec;
					if (expired) begin
						nxt.stop_cnt = stop_load;
						nxt.pstate   = ST_IDLE;
					end
				end
			end
			ST_CSI: begin
				if (!char_valid) begin
					nxt.timer = timer_dec;
					if (expired) nxt.pstate = ST_IDLE;
				end else if (is_digit) begin
					nxt.csi = csi_acc;
				end else begin
					if (char_code == CH_H || char_code == CH_F) key = PK_HOME;
					else if (char_code == CH_TILDE) key = tilde_map(cur.csi);
					else key = cursor_map(char_code);
					nxt.pstate = ST_IDLE;
				end
			end
			default: begin
				if (!char_valid) begin
					nxt.timer = timer_dec;
					if (expired) nxt.pstate = ST_IDLE;
				end else begin
					case (char_code)
						CH_P:    key = PK_F1;
						CH_Q:    key = PK_F2;
						CH_R:    key = PK_F3;
						CH_S:    key = PK_F4;
						default: key = cursor_map(char_code);
					endcase
					nxt.pstate = ST_IDLE;
				end
			end
		endcase
	end

	// key is pushed only below the queue limit
	always_comb begin
		res.key_valid = (key != PK_NONE) && (queue_level < cfg.queue_limit);
		res.key_code  = res.key_valid ? key : PK_NONE;
		res.stop_down = nxt.stop_cnt != 8'd0;
	end

endmodule

// ===== src/ansi_escape_to_petscii_keys.sv =====
`timescale 1ns / 1ps
// path: an accepted item goes into the input register, then into the result register; the
// parser update sits between them
// throughput: one item per cycle while the output is not stalled; the parser state updates with each item
// reset: asynchronous, clears parser state and both stage valids, loads register defaults

module ansi_escape_to_petscii_keys import aepk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       char_valid,
	input  logic [7:0] char_code,
	input  logic [3:0] queue_level,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       key_valid,
	output logic [7:0] key_code,
	output logic       stop_down,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	parse_cfg_t  cfg_q;
	parse_regs_t regs_q;
	parse_regs_t regs_nxt;
	parse_res_t  res;
	logic        valid_s1;
	logic        char_valid_s1;
	logic [7:0]  char_code_s1;
	logic [3:0]  queue_level_s1;
	logic        adv;

	// stage 1 moves on when the result register is free or being taken
	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.escape_timeout <= RST_ESCAPE_TIMEOUT;
			cfg_q.stop_hold      <= RST_STOP_HOLD;
			cfg_q.queue_limit    <= RST_QUEUE_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ESCAPE_TIMEOUT: cfg_q.escape_timeout <= cfg_data;
				REG_STOP_HOLD:      cfg_q.stop_hold      <= cfg_data;
				REG_QUEUE_LIMIT:    cfg_q.queue_limit    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_valid_s1  <= char_valid;
			char_code_s1   <= char_code;
			queue_level_s1 <= queue_level;
		end
	end

	// parser logic
	aepk_step u_step (
		.cur         (regs_q),
		.cfg         (cfg_q),
		.char_valid  (char_valid_s1),
		.char_code   (char_code_s1),
		.queue_level (queue_level_s1),
		.nxt         (regs_nxt),
		.res         (res)
	);

	// parser state advances with the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.pstate   <= ST_IDLE;
			regs_q.timer    <= 8'd0;
			regs_q.csi      <= 8'd0;
			regs_q.stop_cnt <= 8'd0;
		end else if (adv) begin
			regs_q <= regs_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || !out_stall) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_valid <= res.key_valid;
			key_code  <= res.key_code;
			stop_down <= res.stop_down;
		end
	end

	// checks
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty stage");

	a_stop_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (stop_down == (regs_q.stop_cnt != 8'd0)))
		else $error("stop level out of step with hold count");

	a_key_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && key_valid) |-> (key_code != PK_NONE))
		else $error("pushed key has a null code");

	a_adv_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("item lost between stages");

endmodule

// ===== verif/ansi_escape_to_petscii_keys_chk.sv =====
`timescale 1ns / 1ps

module ansi_escape_to_petscii_keys_chk import aepk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic       char_valid,
	input  logic [7:0] char_code,
	input  logic [3:0] queue_level,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       key_valid,
	input  logic [7:0] key_code,
	input  logic       stop_down,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       end_check,
	output int         errors,
	output int         pending
);

	// shadow of the parser and its registers
	parse_state_t ps;
	logic [7:0]   seq_timer;
	logic [7:0]   csi_num;
	logic [7:0]   stop_left;
	logic [7:0]   cfg_esc_timeout;
	logic [7:0]   cfg_stop_hold;
	logic [3:0]   cfg_queue_limit;
	parse_res_t   expected_keys[$];
	bit           leftovers_checked;

	initial begin
		errors = 0;
		pending = 0;
		leftovers_checked = 1'b0;
	end

	// count one mismatch, print only the first few
	task automatic report(input string what);
		errors++;
		if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
	endtask

	// press run/stop, a press while held restarts the hold
	task automatic stop_press();
		stop_left = (cfg_stop_hold != 8'd0) ? cfg_stop_hold : 8'd1;
	endtask

	// one empty frame inside a sequence, 1 when the sequence has run out of time
	function automatic bit seq_expired();
		if (seq_timer <= 8'd1) begin
			seq_timer = 8'd0;
			return 1'b1;
		end
		seq_timer = seq_timer - 8'd1;
		return 1'b0;
	endfunction

	// cursor letters shared by csi and ss3
	function automatic logic [7:0] arrow_key(input logic [7:0] c);
		case (c)
			CH_A:    return PK_UP;
			CH_B:    return PK_DOWN;
			CH_C:    return PK_RIGHT;
			CH_D:    return PK_LEFT;
			default: return PK_NONE;
		endcase
	endfunction

	// bytes outside any sequence
	function automatic logic [7:0] plain_key(input logic [7:0] c);
		if (c == CH_CR || c == CH_LF) return PK_RETURN;
		if (c == CH_BS || c == CH_DEL) return PK_DELETE;
		// lower case folds onto upper case
		if (c >= CH_LC_A && c <= CH_LC_Z) return c - 8'h20;
		if (c >= CH_SPACE && c <= CH_UNDER) return c;
		return PK_NONE;
	endfunction

	// numbered keys ended by a tilde
	function automatic logic [7:0] tilde_key(input logic [7:0] p);
		case (p)
			8'd1, 8'd4: return PK_HOME;
			8'd3:       return PK_DELETE;
			8'd11:      return PK_F1;
			8'd12:      return PK_F2;
			8'd13:      return PK_F3;
			8'd14:      return PK_F4;
			8'd15:      return PK_F5;
			8'd17:      return PK_F6;
			8'd18:      return PK_F7;
			8'd19:      return PK_F8;
			default:    return PK_NONE;
		endcase
	endfunction

	// ss3 finals: function keys f1-f4 or cursor letters
	function automatic logic [7:0] ss3_key(input logic [7:0] c);
		case (c)
			CH_P:    return PK_F1;
			CH_Q:    return PK_F2;
			CH_R:    return PK_F3;
			CH_S:    return PK_F4;
			default: return arrow_key(c);
		endcase
	endfunction

	// advance the shadow parser by one frame and form the result
	task automatic advance_frame(input logic cv, input logic [7:0] c, input logic [3:0] lvl,
			output parse_res_t r);
		logic [7:0] key;
		key = PK_NONE;
		if (stop_left != 8'd0) stop_left = stop_left - 8'd1;
		case (ps)
			ST_IDLE: begin
				if (cv && c == CH_ESC) begin
					ps = ST_ESC;
					seq_timer = cfg_esc_timeout;
				end else if (cv && c == CH_ETX) begin
					stop_press();
				end else if (cv) begin
					key = plain_key(c);
				end
			end
			ST_ESC: begin
				if (cv && c == CH_LBRK) begin
					ps = ST_CSI;
					seq_timer = cfg_esc_timeout;
					csi_num = 8'd0;
				end else if (cv && c == CH_O) begin
					ps = ST_SS3;
					seq_timer = cfg_esc_timeout;
				end else if (cv) begin
					// any other byte after esc is eaten and counts as a bare esc
					stop_press();
					ps = ST_IDLE;
				end else if (seq_expired()) begin
					stop_press();
					ps = ST_IDLE;
				end
			end
			ST_CSI: begin
				if (!cv) begin
					if (seq_expired()) ps = ST_IDLE;
				end else if (c >= CH_ZERO && c <= CH_NINE) begin
					// parameter wraps at 8 bits
					csi_num = csi_num * 8'd10 + (c - CH_ZERO);
				end else begin
					if (c == CH_H || c == CH_F) key = PK_HOME;
					else if (c == CH_TILDE) key = tilde_key(csi_num);
					else key = arrow_key(c);
					ps = ST_IDLE;
				end
			end
			default: begin
				if (!cv) begin
					if (seq_expired()) ps = ST_IDLE;
				end else begin
					key = ss3_key(c);
					ps = ST_IDLE;
				end
			end
		endcase
		r.key_valid = (key != PK_NONE) && (lvl < cfg_queue_limit);
		r.key_code = r.key_valid ? key : PK_NONE;
		r.stop_down = (stop_left != 8'd0);
	endtask

	// compare results, track register writes, predict accepted items
	always @(posedge clk or negedge arst_n) begin : frame_check
		parse_res_t want;
		parse_res_t fresh;
		if (!arst_n) begin
			ps = ST_IDLE;
			seq_timer = 8'd0;
			csi_num = 8'd0;
			stop_left = 8'd0;
			cfg_esc_timeout = RST_ESCAPE_TIMEOUT;
			cfg_stop_hold = RST_STOP_HOLD;
			cfg_queue_limit = RST_QUEUE_LIMIT;
			expected_keys.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_keys.size() == 0) begin
					report("result with no item waiting");
				end else begin
					want = expected_keys.pop_front();
					if (key_valid !== want.key_valid)
						report($sformatf("key_valid %b, expected %b", key_valid, want.key_valid));
					if (key_code !== want.key_code)
						report($sformatf("key_code %h, expected %h", key_code, want.key_code));
					if (stop_down !== want.stop_down)
						report($sformatf("stop_down %b, expected %b", stop_down, want.stop_down));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_ESCAPE_TIMEOUT: cfg_esc_timeout = cfg_data;
					REG_STOP_HOLD:      cfg_stop_hold = cfg_data;
					REG_QUEUE_LIMIT:    cfg_queue_limit = cfg_data[3:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				advance_frame(char_valid, char_code, queue_level, fresh);
				expected_keys.push_back(fresh);
			end
			if (end_check && !leftovers_checked) begin
				leftovers_checked = 1'b1;
				if (expected_keys.size() != 0)
					report($sformatf("%0d results never came", expected_keys.size()));
			end
		end
		pending = expected_keys.size();
	end

endmodule

// ===== verif/ansi_escape_to_petscii_keys_tb.sv =====
`timescale 1ns / 1ps

module ansi_escape_to_petscii_keys_tb import aepk_pkg::*;;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       char_valid;
	logic [7:0] char_code;
	logic [3:0] queue_level;
	logic       out_valid;
	logic       out_stall;
	logic       key_valid;
	logic [7:0] key_code;
	logic       stop_down;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic       end_check;
	int         errors;
	int         pending;

	// stimulus controls
	bit         quiet_tx;
	bit         quiet_rx;
	bit         hold_req;
	int         sent;
	logic [7:0] cur_timeout;
	logic [3:0] cur_limit;

	ansi_escape_to_petscii_keys u_dut (.*);

	ansi_escape_to_petscii_keys_chk u_chk (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// receiver: random stalls, a long hold on request
	initial begin : receiver
		int stall_left;
		int r;
		out_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (60) @(negedge clk);
				hold_req = 1'b0;
				stall_left = 0;
			end else if (quiet_rx) begin
				out_stall = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					out_stall = 1'b0;
				end else begin
					out_stall = 1'b1;
					stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
				end
			end
		end
	end

	// idle frames before an item: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		if (quiet_tx) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// queue level: mostly below the limit so keys get through
	function automatic logic [3:0] pick_level();
		if (cur_limit == 4'd0 || $urandom_range(0, 3) == 0) return 4'($urandom_range(0, 15));
		return 4'($urandom_range(0, cur_limit - 1));
	endfunction

	// offer one item and wait until it is taken
	task automatic send_frame(input logic cv, input logic [7:0] code, input logic [3:0] lvl);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		char_valid = cv;
		char_code = code;
		queue_level = lvl;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_key(input logic [7:0] code);
		send_frame(1'b1, code, pick_level());
	endtask

	task automatic send_empty();
		send_frame(1'b0, 8'($urandom_range(0, 255)), pick_level());
	endtask

	// hold the sender until every result is back
	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// new register setting once the block is idle
	task automatic configure(input logic [7:0] tmo, input logic [7:0] hold, input logic [3:0] lim);
		logic [3:0] junk;
		junk = 4'($urandom_range(0, 15));
		drain();
		write_reg(REG_ESCAPE_TIMEOUT, tmo);
		write_reg(REG_STOP_HOLD, hold);
		// upper bits of the limit write are don't-care
		write_reg(REG_QUEUE_LIMIT, {junk, lim});
		cur_timeout = tmo;
		cur_limit = lim;
	endtask

	// empty frames inside a sequence, sometimes long enough to time it out
	task automatic maybe_pause();
		int lim;
		lim = ((cur_timeout < 8'd6) ? cur_timeout : 6) + 1;
		if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, lim)) send_empty();
	endtask

	// decimal csi parameter, now and then with a leading zero
	task automatic send_number(input int n);
		if ($urandom_range(0, 7) == 0) send_key(CH_ZERO);
		if (n >= 100) send_key(8'(CH_ZERO + n / 100 % 10));
		if (n >= 10) send_key(8'(CH_ZERO + n / 10 % 10));
		send_key(8'(CH_ZERO + n % 10));
	endtask

	function automatic int pick_param();
		case ($urandom_range(0, 14))
			0:  return 1;
			1:  return 3;
			2:  return 4;
			3:  return 11;
			4:  return 12;
			5:  return 13;
			6:  return 14;
			7:  return 15;
			8:  return 17;
			9:  return 18;
			10: return 19;
			11: return $urandom_range(0, 30);
			12: return $urandom_range(0, 999);
			// wraps around to a parameter from 11 to 19
			13: return 256 + $urandom_range(11, 19);
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	function automatic logic [7:0] pick_letter(input bit with_home, input bit with_fkeys);
		case ($urandom_range(0, 9))
			0: return CH_A;
			1: return CH_B;
			2: return CH_C;
			3: return CH_D;
			4: return with_home ? CH_H : CH_A;
			5: return with_home ? CH_F : CH_B;
			6: return with_fkeys ? CH_P : CH_C;
			7: return with_fkeys ? CH_Q : CH_D;
			8: return with_fkeys ? CH_R : CH_A;
			default: return with_fkeys ? CH_S : CH_B;
		endcase
	endfunction

	// one random byte or escape sequence, mostly well formed
	task automatic random_sequence();
		int kind;
		int r;
		int lim;
		kind = $urandom_range(0, 99);
		r = $urandom_range(0, 9);
		if (kind < 30) begin
			send_key(8'($urandom_range(0, 255)));
		end else if (kind < 40) begin
			send_empty();
		end else if (kind < 43) begin
			send_key(CH_ETX);
		end else if (kind < 70) begin
			// csi
			send_key(CH_ESC);
			maybe_pause();
			send_key(CH_LBRK);
			maybe_pause();
			if (r < 5) begin
				send_number(pick_param());
				maybe_pause();
				send_key(CH_TILDE);
			end else if (r < 8) begin
				if (r == 7) send_number($urandom_range(0, 99));
				send_key(pick_letter(1'b1, 1'b0));
			end else begin
				send_key(8'($urandom_range(0, 255)));
			end
		end else if (kind < 88) begin
			// ss3
			send_key(CH_ESC);
			maybe_pause();
			send_key(CH_O);
			maybe_pause();
			if (r < 8) send_key(pick_letter(1'b0, 1'b1));
			else send_key(8'($urandom_range(0, 255)));
		end else begin
			// bare esc: stray byte or timeout
			send_key(CH_ESC);
			lim = ((cur_timeout < 8'd12) ? cur_timeout : 12) + 1;
			if (r < 5) send_key(8'($urandom_range(0, 255)));
			else repeat (lim) send_empty();
		end
	endtask

	task automatic random_items(input int n);
		int stop_at;
		stop_at = sent + n;
		while (sent < stop_at) random_sequence();
	endtask

	// main sequence
	initial begin : stimulus
		int guard;
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_valid = 1'b0;
		char_code = 8'd0;
		queue_level = 4'd0;
		cfg_we = 1'b0;
		cfg_index = REG_ESCAPE_TIMEOUT;
		cfg_data = 8'd0;
		end_check = 1'b0;
		quiet_tx = 1'b0;
		quiet_rx = 1'b0;
		hold_req = 1'b0;
		sent = 0;
		guard = 0;
		cur_timeout = RST_ESCAPE_TIMEOUT;
		cur_limit = RST_QUEUE_LIMIT;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed at reset defaults: field extremes and plain mapping
		send_frame(1'b1, CH_LC_A, 4'd0);
		send_frame(1'b1, CH_LC_Z, 4'd15);
		send_key(8'h00);
		send_key(8'hFF);
		send_key(CH_CR);
		send_key(CH_DEL);
		// stop press, then a second press while still held
		send_key(CH_ETX);
		send_key(CH_ETX);
		// csi function key, ss3 function key
		send_key(CH_ESC);
		send_key(CH_LBRK);
		send_key(8'(CH_ZERO + 1));
		send_key(CH_NINE);
		send_key(CH_TILDE);
		send_key(CH_ESC);
		send_key(CH_O);
		send_key(CH_P);
		// unknown byte after esc
		send_key(CH_ESC);
		send_key(CH_LC_A);
		// esc left alone until it times out
		send_key(CH_ESC);
		repeat (5) send_empty();
		random_items(60);

		// zero registers: instant timeout, one-frame stop, no keys at all
		configure(8'd0, 8'd0, 4'd0);
		send_key(CH_ESC);
		send_empty();
		send_key(CH_ETX);
		send_empty();
		send_key(CH_LC_A);
		random_items(70);

		// upper extremes, with the receiver holding off while the sender keeps going
		configure(8'd255, 8'd255, 4'd15);
		random_items(60);
		quiet_tx = 1'b1;
		hold_req = 1'b1;
		random_items(30);
		quiet_tx = 1'b0;
		random_items(40);

		configure(8'd1, 8'd1, 4'd1);
		random_items(100);

		// back-to-back stretch with no idling on either side
		configure(8'd3, 8'd5, 4'd8);
		quiet_tx = 1'b1;
		quiet_rx = 1'b1;
		random_items(80);
		quiet_tx = 1'b0;
		quiet_rx = 1'b0;

		configure(8'($urandom_range(1, 12)), 8'($urandom_range(1, 255)),
			4'($urandom_range(1, 15)));
		random_items(120);
		configure(8'($urandom_range(1, 255)), 8'($urandom_range(1, 8)),
			4'($urandom_range(1, 15)));
		random_items(120);

		// let the last results out
		in_valid = 1'b0;
		while (pending != 0 && guard < 5000) begin
			@(negedge clk);
			guard++;
		end
		repeat (4) @(negedge clk);
		end_check = 1'b1;
		repeat (2) @(negedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
